@@ src/sector_cache_lru_controller_assert.svh @@
// Assertion macros used by the sector cache controller datapath.
`ifndef SECTOR_CACHE_LRU_CONTROLLER_ASSERT_SVH
`define SECTOR_CACHE_LRU_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCLC_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sector cache controller: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SCLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sector cache controller: assertion failed");

`endif

@@ src/sclc_pkg.sv @@
// Types and constants of the sector cache LRU controller.
`default_nettype none

package sclc_pkg;

   // Command codes of a request word.
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   // Width of the slot fields in a response word.
   localparam int SLOT_OUT_W = 6;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] sector;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  fill_needed;
      logic                  writeback_valid;
      logic [31:0]           writeback_sector;
      logic [SLOT_OUT_W-1:0] writeback_slot;
      logic                  last;
   } rsp_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_PROMOTE,
      ST_PROM_END,
      ST_WB_RD,
      ST_WB_CAP,
      ST_COMMIT,
      ST_FL_START,
      ST_FL_ORD,
      ST_FL_SEC,
      ST_FL_CHK
   } state_type;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_SCAN_RD,
      OP_DECIDE,
      OP_ORD_RD,
      OP_WB_RD,
      OP_WB_CAP,
      OP_COMMIT,
      OP_FL_ORD,
      OP_FL_SEC,
      OP_FL_CHK,
      OP_FL_EMPTY
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic walk_last;
      logic hit;
      logic full;
      logic none_dirty;
      logic flush_last;
   } dp_status_type;

endpackage

`default_nettype wire

@@ src/sclc_ram.sv @@
// Generic single write port RAM with one registered read port.
`default_nettype none

module sclc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/sclc_ctrl.sv @@
// Sequencing state machine of the sector cache LRU controller.
`default_nettype none

module sclc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [1:0]             req_cmd,
   input  wire sclc_pkg::dp_status_type status,
   output logic                        busy,
   output sclc_pkg::dp_cmd_type        cmd
);

   sclc_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sclc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath operation.
   always_comb begin
      state_in = state_ff;
      cmd.op   = sclc_pkg::OP_NOP;
      unique case (state_ff)
         sclc_pkg::ST_IDLE: begin
            if (start) begin
               cmd.op = sclc_pkg::OP_ACCEPT;
               if (req_cmd == sclc_pkg::CMD_READ || req_cmd == sclc_pkg::CMD_WRITE) begin
                  state_in = sclc_pkg::ST_SCAN;
               end else begin
                  state_in = sclc_pkg::ST_FL_START;
               end
            end
         end
         sclc_pkg::ST_SCAN: begin
            cmd.op = sclc_pkg::OP_SCAN_RD;
            if (status.scan_last) begin
               state_in = sclc_pkg::ST_SCAN_END;
            end
         end
         sclc_pkg::ST_SCAN_END: begin
            state_in = sclc_pkg::ST_DECIDE;
         end
         sclc_pkg::ST_DECIDE: begin
            cmd.op = sclc_pkg::OP_DECIDE;
            if (status.hit || status.full) begin
               state_in = sclc_pkg::ST_PROMOTE;
            end else begin
               state_in = sclc_pkg::ST_COMMIT;
            end
         end
         sclc_pkg::ST_PROMOTE: begin
            cmd.op = sclc_pkg::OP_ORD_RD;
            if (status.walk_last) begin
               state_in = sclc_pkg::ST_PROM_END;
            end
         end
         sclc_pkg::ST_PROM_END: begin
            if (status.hit) begin
               state_in = sclc_pkg::ST_COMMIT;
            end else begin
               state_in = sclc_pkg::ST_WB_RD;
            end
         end
         sclc_pkg::ST_WB_RD: begin
            cmd.op   = sclc_pkg::OP_WB_RD;
            state_in = sclc_pkg::ST_WB_CAP;
         end
         sclc_pkg::ST_WB_CAP: begin
            cmd.op   = sclc_pkg::OP_WB_CAP;
            state_in = sclc_pkg::ST_COMMIT;
         end
         sclc_pkg::ST_COMMIT: begin
            cmd.op   = sclc_pkg::OP_COMMIT;
            state_in = sclc_pkg::ST_IDLE;
         end
         sclc_pkg::ST_FL_START: begin
            if (status.none_dirty) begin
               cmd.op   = sclc_pkg::OP_FL_EMPTY;
               state_in = sclc_pkg::ST_IDLE;
            end else begin
               state_in = sclc_pkg::ST_FL_ORD;
            end
         end
         sclc_pkg::ST_FL_ORD: begin
            cmd.op   = sclc_pkg::OP_FL_ORD;
            state_in = sclc_pkg::ST_FL_SEC;
         end
         sclc_pkg::ST_FL_SEC: begin
            cmd.op   = sclc_pkg::OP_FL_SEC;
            state_in = sclc_pkg::ST_FL_CHK;
         end
         sclc_pkg::ST_FL_CHK: begin
            cmd.op = sclc_pkg::OP_FL_CHK;
            if (status.flush_last) begin
               state_in = sclc_pkg::ST_IDLE;
            end else begin
               state_in = sclc_pkg::ST_FL_ORD;
            end
         end
         default: begin
            state_in = sclc_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != sclc_pkg::ST_IDLE);

endmodule

`default_nettype wire

@@ src/sclc_datapath.sv @@
// Tag store, recency list, valid and dirty bits of the sector cache.
`default_nettype none
`include "sector_cache_lru_controller_assert.svh"

module sclc_datapath #(
   parameter int ENTRIES = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sclc_pkg::dp_cmd_type    cmd,
   input  wire sclc_pkg::req_type       req_word,
   output sclc_pkg::dp_status_type      status,
   output logic                         rsp_strobe,
   output sclc_pkg::rsp_type            rsp_word
);

   localparam int SLOT_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int EXT_W  = SLOT_W + sclc_pkg::SLOT_OUT_W;

   // Latched request and scan state.
   logic [1:0]          cmd_ff, cmd_in;
   logic [31:0]         sector_ff, sector_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                hit_ff, hit_in;
   logic [SLOT_W-1:0]   hit_slot_ff, hit_slot_in;
   logic                free_found_ff, free_found_in;
   logic [SLOT_W-1:0]   free_slot_ff, free_slot_in;
   logic [SLOT_W-1:0]   target_ff, target_in;
   logic                evict_ff, evict_in;
   logic                found_ff, found_in;
   logic [31:0]         wb_sector_ff, wb_sector_in;
   logic [SLOT_W-1:0]   fl_slot_ff, fl_slot_in;
   logic                rd_scan_ff, rd_scan_in;
   logic                rd_prom_ff, rd_prom_in;
   logic [SLOT_W-1:0]   rd_idx_ff, rd_idx_in;

   // Cache bookkeeping.
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [ENTRIES-1:0]  dirty_ff, dirty_in;
   logic [CNT_W-1:0]    held_ff, held_in;
   logic [CNT_W-1:0]    dirty_cnt_ff, dirty_cnt_in;

   // Result register.
   logic                rsp_strobe_ff, rsp_strobe_in;
   sclc_pkg::rsp_type   rsp_ff, rsp_in;

   // Memory ports.
   logic                sec_we;
   logic [SLOT_W-1:0]   sec_waddr;
   logic [31:0]         sec_wdata;
   logic [SLOT_W-1:0]   sec_raddr;
   logic [31:0]         sec_rdata;
   logic                ord_we;
   logic [SLOT_W-1:0]   ord_waddr;
   logic [SLOT_W-1:0]   ord_wdata;
   logic [SLOT_W-1:0]   ord_raddr;
   logic [SLOT_W-1:0]   ord_rdata;

   // Helpers.
   logic                full;
   logic                is_write;
   logic                old_dirty;
   logic                new_dirty;
   logic                wb_valid;
   logic [CNT_W-1:0]    tail_rank;
   logic [EXT_W-1:0]    tgt_ext;
   logic [EXT_W-1:0]    fl_ext;

   // Sector tag of each slot.
   sclc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_sector_ram (
      .clock   (clock),
      .wr_en   (sec_we),
      .wr_addr (sec_waddr),
      .wr_data (sec_wdata),
      .rd_addr (sec_raddr),
      .rd_data (sec_rdata)
   );

   // Recency list: slot held at each rank, least recent first.
   sclc_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_waddr),
      .wr_data (ord_wdata),
      .rd_addr (ord_raddr),
      .rd_data (ord_rdata)
   );

   assign full      = (held_ff == CNT_W'(ENTRIES));
   assign is_write  = (cmd_ff == sclc_pkg::CMD_WRITE);
   assign old_dirty = dirty_ff[target_ff];
   assign new_dirty = hit_ff ? (old_dirty | is_write) : is_write;
   assign wb_valid  = evict_ff & old_dirty;
   assign tail_rank = (hit_ff || evict_ff) ? CNT_W'(held_ff - 1'b1) : held_ff;
   assign tgt_ext   = EXT_W'(target_ff);
   assign fl_ext    = EXT_W'(fl_slot_ff);

   // Status toward the controller.
   assign status.scan_last  = (idx_ff == CNT_W'(ENTRIES - 1));
   assign status.walk_last  = (idx_ff == CNT_W'(held_ff - 1'b1));
   assign status.hit        = hit_ff;
   assign status.full       = full;
   assign status.none_dirty = (dirty_cnt_ff == '0);
   assign status.flush_last = dirty_ff[fl_slot_ff] && (dirty_cnt_ff == CNT_W'(1));

   // Next-state logic of the datapath.
   always_comb begin
      cmd_in        = cmd_ff;
      sector_in     = sector_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      target_in     = target_ff;
      evict_in      = evict_ff;
      found_in      = found_ff;
      wb_sector_in  = wb_sector_ff;
      fl_slot_in    = fl_slot_ff;
      rd_scan_in    = 1'b0;
      rd_prom_in    = 1'b0;
      rd_idx_in     = idx_ff[SLOT_W-1:0];
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      held_in       = held_ff;
      dirty_cnt_in  = dirty_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      sec_we        = 1'b0;
      sec_waddr     = target_ff;
      sec_wdata     = sector_ff;
      sec_raddr     = idx_ff[SLOT_W-1:0];
      ord_we        = 1'b0;
      ord_waddr     = tail_rank[SLOT_W-1:0];
      ord_wdata     = ord_rdata;
      ord_raddr     = idx_ff[SLOT_W-1:0];

      // Tag compare and free slot search on the word read last cycle.
      if (rd_scan_ff) begin
         if (valid_ff[rd_idx_ff] && (sec_rdata == sector_ff) && !hit_ff) begin
            hit_in      = 1'b1;
            hit_slot_in = rd_idx_ff;
         end
         if (!valid_ff[rd_idx_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = rd_idx_ff;
         end
      end

      // Recency walk: ranks above the promoted slot move down by one.
      if (rd_prom_ff) begin
         if (!found_ff) begin
            if (evict_ff ? (rd_idx_ff == '0) : (ord_rdata == target_ff)) begin
               found_in  = 1'b1;
               target_in = ord_rdata;
            end
         end else begin
            ord_we    = 1'b1;
            ord_waddr = SLOT_W'(rd_idx_ff - 1'b1);
            ord_wdata = ord_rdata;
         end
      end

      unique case (cmd.op)
         sclc_pkg::OP_ACCEPT: begin
            cmd_in        = req_word.cmd;
            sector_in     = req_word.sector;
            idx_in        = '0;
            hit_in        = 1'b0;
            free_found_in = 1'b0;
         end
         sclc_pkg::OP_SCAN_RD: begin
            rd_scan_in = 1'b1;
            idx_in     = idx_ff + 1'b1;
         end
         sclc_pkg::OP_DECIDE: begin
            target_in = hit_ff ? hit_slot_ff : free_slot_ff;
            evict_in  = !hit_ff && full;
            found_in  = 1'b0;
            idx_in    = '0;
         end
         sclc_pkg::OP_ORD_RD: begin
            rd_prom_in = 1'b1;
            idx_in     = idx_ff + 1'b1;
         end
         sclc_pkg::OP_WB_RD: begin
            sec_raddr = target_ff;
         end
         sclc_pkg::OP_WB_CAP: begin
            wb_sector_in = sec_rdata;
         end
         sclc_pkg::OP_COMMIT: begin
            sec_we               = 1'b1;
            ord_we               = 1'b1;
            ord_waddr            = tail_rank[SLOT_W-1:0];
            ord_wdata            = target_ff;
            valid_in[target_ff]  = 1'b1;
            dirty_in[target_ff]  = new_dirty;
            dirty_cnt_in         = dirty_cnt_ff + CNT_W'(new_dirty) - CNT_W'(old_dirty);
            if (!hit_ff && !evict_ff) begin
               held_in = held_ff + 1'b1;
            end
            rsp_strobe_in          = 1'b1;
            rsp_in.hit             = hit_ff;
            rsp_in.slot            = tgt_ext[sclc_pkg::SLOT_OUT_W-1:0];
            rsp_in.fill_needed     = !hit_ff;
            rsp_in.writeback_valid = wb_valid;
            rsp_in.writeback_sector = wb_valid ? wb_sector_ff : 32'd0;
            rsp_in.writeback_slot  = wb_valid ? tgt_ext[sclc_pkg::SLOT_OUT_W-1:0] : '0;
            rsp_in.last            = 1'b1;
         end
         sclc_pkg::OP_FL_ORD: begin
            ord_raddr = idx_ff[SLOT_W-1:0];
         end
         sclc_pkg::OP_FL_SEC: begin
            fl_slot_in = ord_rdata;
            sec_raddr  = ord_rdata;
         end
         sclc_pkg::OP_FL_CHK: begin
            idx_in = idx_ff + 1'b1;
            if (dirty_ff[fl_slot_ff]) begin
               dirty_in[fl_slot_ff]    = 1'b0;
               dirty_cnt_in            = dirty_cnt_ff - 1'b1;
               rsp_strobe_in           = 1'b1;
               rsp_in.writeback_valid  = 1'b1;
               rsp_in.writeback_sector = sec_rdata;
               rsp_in.writeback_slot   = fl_ext[sclc_pkg::SLOT_OUT_W-1:0];
               rsp_in.last             = status.flush_last;
            end
            if (status.flush_last && (cmd_ff == sclc_pkg::CMD_CLEAR)) begin
               valid_in = '0;
               held_in  = '0;
            end
         end
         sclc_pkg::OP_FL_EMPTY: begin
            rsp_strobe_in = 1'b1;
            rsp_in.last   = 1'b1;
            if (cmd_ff == sclc_pkg::CMD_CLEAR) begin
               valid_in = '0;
               held_in  = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         dirty_ff      <= '0;
         held_ff       <= '0;
         dirty_cnt_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
         rd_scan_ff    <= 1'b0;
         rd_prom_ff    <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         dirty_ff      <= dirty_in;
         held_ff       <= held_in;
         dirty_cnt_ff  <= dirty_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rd_scan_ff    <= rd_scan_in;
         rd_prom_ff    <= rd_prom_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      sector_ff     <= sector_in;
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      hit_slot_ff   <= hit_slot_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      target_ff     <= target_in;
      evict_ff      <= evict_in;
      found_ff      <= found_in;
      wb_sector_ff  <= wb_sector_in;
      fl_slot_ff    <= fl_slot_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

   // The held count never exceeds the slot count, and dirty entries are held ones.
   `SCLC_ASSERT_HOLDS(a_held_bound, clock, reset, 1'b1, held_ff <= CNT_W'(ENTRIES))
   `SCLC_ASSERT_HOLDS(a_dirty_bound, clock, reset, 1'b1, dirty_cnt_ff <= held_ff)
   // An append always has a free slot to take.
   `SCLC_ASSERT_HOLDS(a_free_on_append, clock, reset,
      (cmd.op == sclc_pkg::OP_COMMIT) && !hit_ff && !evict_ff, free_found_ff)
   // Every commit delivers exactly one final word.
   `SCLC_ASSERT_NEXT(a_commit_word, clock, reset,
      cmd.op == sclc_pkg::OP_COMMIT, rsp_strobe_ff && rsp_ff.last)

endmodule

`default_nettype wire

@@ src/sector_cache_lru_controller.sv @@
// Top level of the sector cache tag, dirty and LRU controller.
//
//   Channel   Ports                          Handshake
//   request   start, busy, req_word          taken when start is high and busy low
//   response  rsp_strobe, rsp_word           one cycle per word, cannot be held off
//
// A read or write keeps busy high through the tag scan of every slot, then scan end,
// decide and commit when it takes a free slot. A hit adds a walk of the held ranks
// to move the recency list, and an eviction adds that walk and the victim tag read
// and capture. Its word comes out in the cycle after the commit.
// Flush and clear keep busy high for a start state, then an order RAM read, a sector
// RAM read and a check per rank walked up to the last dirty entry.
// Reset clears valid and dirty bits at once; no clearing pass is needed.
// busy drops at the edge that puts the final word of a command on the ports.
`default_nettype none

module sector_cache_lru_controller #(
   parameter int ENTRIES = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire sclc_pkg::req_type req_word,
   output logic                   rsp_strobe,
   output sclc_pkg::rsp_type      rsp_word
);

   sclc_pkg::dp_cmd_type    dp_cmd;
   sclc_pkg::dp_status_type dp_status;

   // Sequencer.
   sclc_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_word.cmd),
      .status  (dp_status),
      .busy    (busy),
      .cmd     (dp_cmd)
   );

   // Tag, recency and dirty datapath.
   sclc_datapath #(.ENTRIES(ENTRIES)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dp_cmd),
      .req_word   (req_word),
      .status     (dp_status),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

`default_nettype wire
